@@ rtl/gba_pkg.sv @@
// Shared constants and types for the gyro bias auto calibrator.
// Holds field widths, register indexes and reset values; depends on nothing.
package gba_pkg;

    localparam int WINDOW_DEF = 30;
    localparam int AXES       = 3;

    localparam int GYRO_W = 16;
    localparam int TEMP_W = 16;
    localparam int SUM_W  = 22;   // signed window sum, holds 64 x 16-bit samples
    localparam int ABS_W  = 22;   // magnitude of a window sum
    localparam int QSUM_W = 37;   // sum of squares, holds 64 x 2^30
    localparam int SQ_W   = 44;
    localparam int VAR_W  = 46;
    localparam int ASUM_W = 24;
    localparam int MB_W   = 25;
    localparam int COR_W  = 25;
    localparam int OFF_W  = 24;
    localparam int CNT_W  = 16;
    localparam int QUO_W  = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;

    localparam int IDX_W = 8;
    localparam int CFG_W = 18;

    localparam logic [IDX_W-1:0] REG_TEMP_TARGET = 8'd0;
    localparam logic [IDX_W-1:0] REG_DEV_LIMIT   = 8'd1;
    localparam logic [IDX_W-1:0] REG_MEAN_LIMIT  = 8'd2;
    localparam logic [IDX_W-1:0] REG_STILL_LIMIT = 8'd3;

    localparam logic [7:0]  TEMP_TARGET_RST = 8'd40;
    localparam logic [15:0] DEV_LIMIT_RST   = 16'd45;
    localparam logic [17:0] MEAN_LIMIT_RST  = 18'd75;
    localparam logic [15:0] STILL_LIMIT_RST = 16'd4000;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef logic signed [GYRO_W-1:0] t_gyro;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [ABS_W-1:0]         t_abs;
    typedef logic [QSUM_W-1:0]        t_qsum;
    typedef logic signed [OFF_W-1:0]  t_off;
    typedef logic signed [COR_W-1:0]  t_cor;

endpackage

@@ rtl/gyro_bias_auto_calibrator.sv @@
// Top level of the gyro bias auto calibrator: sample window, running statistics,
// stillness detection and offset latch. Depends on gba_pkg.
//
// The block takes one gyro word per clock while the output is not stalled and
// returns one corrected word per input, registered through the five stages of
// the statistics pipeline; the only loops are the running sums, the stillness
// counter and the offset latch, each closed within one stage. The WINDOW-deep
// sample history is a memory read one entry ahead of the write pointer; its
// entries count as zero until first written, so no clearing pass follows reset.
// Limit registers may be written whenever no word is in flight.
module gyro_bias_auto_calibrator
    import gba_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // gyro_x[15:0], gyro_y[31:16], gyro_z[47:32], temp_raw[63:48]
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // corrected_x[24:0], corrected_y[49:25], corrected_z[74:50],
    // still_count[90:75], zero fill[95:91]
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // calibrated[0]
    output logic                    o_m_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int IDXW = $clog2(WINDOW);
    localparam int K_SH = ABS_W + IDXW;
    localparam longint RECIP_L = (longint'(1) <<< K_SH) / WINDOW + 1;
    localparam logic [ABS_W:0] RECIP = (ABS_W + 1)'(RECIP_L);
    localparam logic [IDXW-1:0] LAST = IDXW'(WINDOW - 1);
    localparam longint DEV_RST_L = longint'(DEV_LIMIT_RST) * longint'(DEV_LIMIT_RST);
    localparam logic [31:0] DEV_SQ_RST = 32'(DEV_RST_L);
    localparam logic [VAR_W-1:0] DEV_BOUND_RST = VAR_W'(DEV_RST_L * WINDOW * WINDOW);
    localparam logic [MB_W-1:0] MEAN_BOUND_RST = MB_W'(longint'(MEAN_LIMIT_RST) * WINDOW);

    // ---------------- configuration ----------------
    logic [7:0]             r_temp_target;
    logic [15:0]            r_dev_limit;
    logic [17:0]            r_mean_limit;
    logic [15:0]            r_still_limit;
    logic [31:0]            r_dev_sq;
    logic [VAR_W-1:0]       r_dev_bound;
    logic [MB_W-1:0]        r_mean_bound;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_target <= TEMP_TARGET_RST;
            r_dev_limit   <= DEV_LIMIT_RST;
            r_mean_limit  <= MEAN_LIMIT_RST;
            r_still_limit <= STILL_LIMIT_RST;
            r_dev_sq      <= DEV_SQ_RST;
            r_dev_bound   <= DEV_BOUND_RST;
            r_mean_bound  <= MEAN_BOUND_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TEMP_TARGET: r_temp_target <= i_cfg_data[7:0];
                    REG_DEV_LIMIT:   r_dev_limit   <= i_cfg_data[15:0];
                    REG_MEAN_LIMIT:  r_mean_limit  <= i_cfg_data[17:0];
                    REG_STILL_LIMIT: r_still_limit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // The squared deviation bound passes through r_dev_sq and r_dev_bound after a write;
            // the bounds settle before any new word can reach the comparison stage.
            r_dev_sq     <= 32'(r_dev_limit) * 32'(r_dev_limit);
            r_dev_bound  <= VAR_W'(r_dev_sq) * VAR_W'(WINDOW * WINDOW);
            r_mean_bound <= MB_W'(r_mean_limit) * MB_W'(WINDOW);
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_out_vld;
    logic en1, en2, en3, en4, en_out, accept;

    assign en_out = !r_out_vld || i_m_axis_tready;
    assign en4    = !r_p4_vld || en_out;
    assign en3    = !r_p3_vld || en4;
    assign en2    = !r_p2_vld || en3;
    assign en1    = !r_p1_vld || en2;
    assign accept = i_s_axis_tvalid && en1;

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1)    r_p1_vld  <= i_s_axis_tvalid;
            if (en2)    r_p2_vld  <= r_p1_vld;
            if (en3)    r_p3_vld  <= r_p2_vld;
            if (en4)    r_p4_vld  <= r_p3_vld;
            if (en_out) r_out_vld <= r_p4_vld;
        end
    end

    // ---------------- sample window ----------------
    logic [3*GYRO_W-1:0]    r_win [WINDOW];
    logic [WINDOW-1:0]      r_win_vld;
    logic [IDXW-1:0]        r_ptr;
    logic [IDXW-1:0]        n_ptr;
    logic [3*GYRO_W-1:0]    r_old_data;
    logic                   r_old_vld;

    assign n_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    // r_old_data always holds the entry that the next word will replace.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[r_ptr] <= i_s_axis_tdata[3*GYRO_W-1:0];
            r_old_data   <= r_win[n_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
            r_ptr     <= '0;
            r_old_vld <= 1'b0;
        end else if (accept) begin
            r_win_vld[r_ptr] <= 1'b1;
            r_ptr            <= n_ptr;
            r_old_vld        <= r_win_vld[n_ptr];
        end
    end

    // ---------------- stage 1: window sums ----------------
    t_gyro                  r_p1_g   [AXES];
    t_gyro                  r_p1_old [AXES];
    logic [TEMP_W-1:0]      r_p1_temp;
    t_sum                   r_sum    [AXES];
    t_sum                   n_sum    [AXES];
    logic signed [31:0]     sqd      [AXES];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int a = 0; a < AXES; a++) begin
                r_p1_g[a]   <= i_s_axis_tdata[a*GYRO_W +: GYRO_W];
                r_p1_old[a] <= r_old_vld ? r_old_data[a*GYRO_W +: GYRO_W] : '0;
            end
            r_p1_temp <= i_s_axis_tdata[3*GYRO_W +: TEMP_W];
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(r_p1_g[a]) - SUM_W'(r_p1_old[a]);
            sqd[a]   = 32'(r_p1_g[a] * r_p1_g[a]) - 32'(r_p1_old[a] * r_p1_old[a]);
        end
    end

    // ---------------- stage 2: sums of squares, products ----------------
    t_sum                   r_p2_sum  [AXES];
    logic signed [31:0]     r_p2_sqd  [AXES];
    t_gyro                  r_p2_g    [AXES];
    logic [TEMP_W-1:0]      r_p2_temp;
    t_qsum                  r_qsum    [AXES];
    t_qsum                  n_qsum    [AXES];
    t_abs                   abs_s     [AXES];
    logic [SQ_W-1:0]        sq_s      [AXES];
    logic [ABS_W+ABS_W:0]   qp_s      [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) r_sum[a] <= '0;
        end else if (en2 && r_p1_vld) begin
            for (int a = 0; a < AXES; a++) r_sum[a] <= n_sum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int a = 0; a < AXES; a++) begin
                r_p2_sum[a] <= n_sum[a];
                r_p2_sqd[a] <= sqd[a];
                r_p2_g[a]   <= r_p1_g[a];
            end
            r_p2_temp <= r_p1_temp;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_qsum[a] = r_qsum[a] + t_qsum'(QSUM_W'(r_p2_sqd[a]));
            abs_s[a]  = r_p2_sum[a][SUM_W-1] ? t_abs'(-r_p2_sum[a]) : t_abs'(r_p2_sum[a]);
            sq_s[a]   = SQ_W'(abs_s[a]) * SQ_W'(abs_s[a]);
            // Reciprocal multiply gives the exact quotient of |S| by WINDOW.
            qp_s[a]   = (ABS_W + ABS_W + 1)'(abs_s[a]) * (ABS_W + ABS_W + 1)'(RECIP);
        end
    end

    // ---------------- stage 3: variances, quotient and remainder ----------------
    t_qsum                  r_p3_qsum [AXES];
    logic [SQ_W-1:0]        r_p3_sq   [AXES];
    t_abs                   r_p3_abs  [AXES];
    logic                   r_p3_neg  [AXES];
    logic [ABS_W+ABS_W:0]   r_p3_qp   [AXES];
    t_gyro                  r_p3_g    [AXES];
    logic [TEMP_W-1:0]      r_p3_temp;
    logic [SQ_W-1:0]        var_a     [AXES];
    logic [QUO_W-1:0]       quo       [AXES];
    logic [IDXW-1:0]        rem       [AXES];
    logic [ASUM_W-1:0]      abs_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) r_qsum[a] <= '0;
        end else if (en3 && r_p2_vld) begin
            for (int a = 0; a < AXES; a++) r_qsum[a] <= n_qsum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int a = 0; a < AXES; a++) begin
                r_p3_qsum[a] <= n_qsum[a];
                r_p3_sq[a]   <= sq_s[a];
                r_p3_abs[a]  <= abs_s[a];
                r_p3_neg[a]  <= r_p2_sum[a][SUM_W-1];
                r_p3_qp[a]   <= qp_s[a];
                r_p3_g[a]    <= r_p2_g[a];
            end
            r_p3_temp <= r_p2_temp;
        end
    end

    always_comb begin
        abs_sum = '0;
        for (int a = 0; a < AXES; a++) begin
            var_a[a] = SQ_W'(r_p3_qsum[a]) * SQ_W'(WINDOW) - r_p3_sq[a];
            quo[a]   = r_p3_qp[a][K_SH +: QUO_W];
            rem[a]   = IDXW'(r_p3_abs[a] - ABS_W'(ABS_W'(quo[a]) * ABS_W'(WINDOW)));
            abs_sum  = abs_sum + ASUM_W'(r_p3_abs[a]);
        end
    end

    // ---------------- stage 4: stillness test, rounded means ----------------
    logic [SQ_W-1:0]        r_p4_var  [AXES];
    logic [ASUM_W-1:0]      r_p4_abs_sum;
    logic [QUO_W-1:0]       r_p4_quo  [AXES];
    logic [IDXW-1:0]        r_p4_rem  [AXES];
    logic                   r_p4_neg  [AXES];
    t_gyro                  r_p4_g    [AXES];
    logic [TEMP_W-1:0]      r_p4_temp;
    logic [7:0]             frac_tab  [2**IDXW];
    logic [VAR_W-1:0]       var_sum;
    logic                   still;
    logic [OFF_W-1:0]       mag       [AXES];
    t_off                   cand      [AXES];
    logic signed [17:0]     temp_thr;
    logic                   temp_ok;

    // Rounded fraction of a remainder: (r * 256 / WINDOW), ties away from zero.
    for (genvar r = 0; r < 2**IDXW; r++) begin : g_frac
        assign frac_tab[r] = (r < WINDOW) ? 8'((r * 512 + WINDOW) / (2 * WINDOW)) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int a = 0; a < AXES; a++) begin
                r_p4_var[a] <= var_a[a];
                r_p4_quo[a] <= quo[a];
                r_p4_rem[a] <= rem[a];
                r_p4_neg[a] <= r_p3_neg[a];
                r_p4_g[a]   <= r_p3_g[a];
            end
            r_p4_abs_sum <= abs_sum;
            r_p4_temp    <= r_p3_temp;
        end
    end

    always_comb begin
        var_sum = '0;
        for (int a = 0; a < AXES; a++) begin
            var_sum = var_sum + VAR_W'(r_p4_var[a]);
            mag[a]  = {r_p4_quo[a], 8'h00} + OFF_W'(frac_tab[r_p4_rem[a]]);
            cand[a] = r_p4_neg[a] ? -$signed(mag[a]) : $signed(mag[a]);
        end
        still    = (var_sum < r_dev_bound) && (MB_W'(r_p4_abs_sum) < r_mean_bound);
        temp_thr = $signed({2'b00, r_temp_target, 8'h00}) - 18'sd512;
        temp_ok  = $signed({2'b00, r_p4_temp}) > temp_thr;
    end

    // ---------------- result stage: counter, latch, correction ----------------
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_latched;
    t_off                   r_off     [AXES];
    t_cor                   r_out_cor [AXES];
    logic                   r_out_cal;
    logic [CNT_W-1:0]       r_out_cnt;
    logic                   gate;
    logic                   latch_now;
    logic [CNT_W-1:0]       n_cnt;
    t_cor                   g256      [AXES];
    t_cor                   c_keep    [AXES];
    t_cor                   c_new     [AXES];

    always_comb begin
        gate = temp_ok && !r_latched;
        if (!gate) begin
            n_cnt = r_cnt;
        end else if (!still) begin
            n_cnt = '0;
        end else if (r_cnt == CNT_MAX) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
        latch_now = gate && (n_cnt > r_still_limit);
        for (int a = 0; a < AXES; a++) begin
            g256[a]   = COR_W'($signed({r_p4_g[a], 8'h00}));
            c_keep[a] = g256[a] - COR_W'(r_off[a]);
            c_new[a]  = g256[a] - COR_W'(cand[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_latched <= 1'b0;
            for (int a = 0; a < AXES; a++) r_off[a] <= '0;
        end else if (en_out && r_p4_vld) begin
            r_cnt <= n_cnt;
            if (latch_now) begin
                r_latched <= 1'b1;
                for (int a = 0; a < AXES; a++) r_off[a] <= cand[a];
            end
        end
    end

    // Offsets latched by this word already apply to its own result.
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            for (int a = 0; a < AXES; a++) begin
                r_out_cor[a] <= latch_now ? c_new[a] : c_keep[a];
            end
            r_out_cal <= r_latched || latch_now;
            r_out_cnt <= n_cnt;
        end
    end

    assign o_m_axis_tdata = {5'b0, r_out_cnt, r_out_cor[2], r_out_cor[1], r_out_cor[0]};
    assign o_m_axis_tuser = r_out_cal;

endmodule
